// File: hdl/flight_mode_arming_controller_macros.svh
// ----------------------------------------------------------------------------
// Flight mode arming controller assertion macros
// Concurrent assertion wrappers used by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef FLIGHT_MODE_ARMING_CONTROLLER_MACROS_SVH
`define FLIGHT_MODE_ARMING_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
`define FMAC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FMAC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FMAC_ASSERT(label, prop, msg)
`define FMAC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: hdl/fmac_pkg.sv
// ----------------------------------------------------------------------------
// Flight mode arming controller package
// Codes, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package fmac_pkg;

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_NORMAL = 2'd1;
   localparam logic [1:0] MODE_HOLD   = 2'd2;
   localparam logic [1:0] MODE_FAIL   = 2'd3;

   localparam logic [2:0] PH_FREE   = 3'd0;
   localparam logic [2:0] PH_MAX    = 3'd1;
   localparam logic [2:0] PH_LEFT   = 3'd2;
   localparam logic [2:0] PH_MIN    = 3'd3;
   localparam logic [2:0] PH_UNLOCK = 3'd4;

   localparam logic [1:0] REG_MISS_LIMIT     = 2'd0;
   localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd2;
   localparam logic [1:0] REG_HOLD_MS        = 2'd3;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [7:0]  MISS_LIMIT_RESET     = 8'd10;
   localparam logic [9:0]  HIGH_THRESHOLD_RESET = 10'd900;
   localparam logic [9:0]  LOW_THRESHOLD_RESET  = 10'd100;
   localparam logic [15:0] HOLD_MS_RESET        = 16'd1000;

   localparam logic [9:0] THROTTLE_MAX = 10'd1000;

   typedef struct packed {
      logic [7:0]  miss_limit;
      logic [9:0]  high_threshold;
      logic [9:0]  low_threshold;
      logic [15:0] hold_ms;
   } cfg_type;

   typedef struct packed {
      logic        rx_ok;
      logic [9:0]  throttle;
      logic        height_toggle;
      logic [31:0] now_ms;
      logic [15:0] distance_mm;
      logic        motors_stopped;
   } item_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  phase;
      logic        link;
      logic [7:0]  miss_count;
      logic [31:0] max_entry_time;
      logic [31:0] min_entry_time;
      logic [9:0]  last_throttle;
      logic        pending_toggle;
      logic [15:0] height;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode: MODE_IDLE, phase: PH_FREE, link: 1'b0, miss_count: 8'd0,
      max_entry_time: 32'd0, min_entry_time: 32'd0, last_throttle: 10'd0,
      pending_toggle: 1'b0, height: 16'd0
   };

endpackage

// File: hdl/fmac_channels.sv
// ----------------------------------------------------------------------------
// Flight mode arming controller channels
// Valid/ready interfaces for the control period items and the results.
// ----------------------------------------------------------------------------
interface fmac_req_if;
   logic        valid;
   logic        ready;
   logic        rx_ok;
   logic [9:0]  throttle;
   logic        height_toggle;
   logic [31:0] now_ms;
   logic [15:0] distance_mm;
   logic        motors_stopped;

   modport source (
      output valid, rx_ok, throttle, height_toggle, now_ms, distance_mm, motors_stopped,
      input  ready
   );
   modport sink (
      input  valid, rx_ok, throttle, height_toggle, now_ms, distance_mm, motors_stopped,
      output ready
   );
endinterface

interface fmac_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  flight_mode;
   logic [2:0]  arm_phase;
   logic        link_up;
   logic [15:0] held_height;

   modport source (
      output valid, flight_mode, arm_phase, link_up, held_height,
      input  ready
   );
   modport sink (
      input  valid, flight_mode, arm_phase, link_up, held_height,
      output ready
   );
endinterface

// File: hdl/fmac_step.sv
// ----------------------------------------------------------------------------
// Flight mode arming controller update logic
// Link supervision, arming sequence and flight mode transition for one period.
// ----------------------------------------------------------------------------
module fmac_step (
   input  fmac_pkg::cfg_type   cfg,
   input  fmac_pkg::item_type  item,
   input  fmac_pkg::state_type state,
   output fmac_pkg::state_type state_next
);
   import fmac_pkg::*;

   state_type   link_st;
   logic [7:0]  miss_inc;
   logic [31:0] max_elapsed;
   logic [31:0] min_elapsed;
   logic [31:0] hold_wide;
   logic [2:0]  phase_adv;
   logic [31:0] max_time_adv;
   logic [31:0] min_time_adv;

   assign hold_wide   = {16'd0, cfg.hold_ms};
   assign miss_inc    = state.miss_count + 8'd1;
   assign max_elapsed = item.now_ms - state.max_entry_time;
   assign min_elapsed = item.now_ms - state.min_entry_time;

   always_comb begin
      link_st = state;
      if (item.rx_ok) begin
         link_st.link           = 1'b1;
         link_st.miss_count     = 8'd0;
         link_st.last_throttle  = (item.throttle > THROTTLE_MAX) ? THROTTLE_MAX
                                                                 : item.throttle;
         link_st.pending_toggle = item.height_toggle;
      end else if (miss_inc >= cfg.miss_limit) begin
         link_st.link       = 1'b0;
         link_st.miss_count = 8'd0;
      end else begin
         link_st.miss_count = miss_inc;
      end
   end

   always_comb begin
      phase_adv    = state.phase;
      max_time_adv = state.max_entry_time;
      min_time_adv = state.min_entry_time;
      unique case (state.phase)
         PH_FREE: begin
            if (link_st.last_throttle >= cfg.high_threshold) begin
               phase_adv    = PH_MAX;
               max_time_adv = item.now_ms;
            end
         end
         PH_MAX: begin
            if (link_st.last_throttle < cfg.high_threshold) begin
               phase_adv = (max_elapsed >= hold_wide) ? PH_LEFT : PH_FREE;
            end
         end
         PH_LEFT: begin
            if (link_st.last_throttle <= cfg.low_threshold) begin
               phase_adv    = PH_MIN;
               min_time_adv = item.now_ms;
            end
         end
         PH_MIN: begin
            if (min_elapsed > hold_wide) begin
               phase_adv = PH_UNLOCK;
            end else if (link_st.last_throttle > cfg.low_threshold) begin
               phase_adv = PH_FREE;
            end
         end
         default: begin
            phase_adv = state.phase;
         end
      endcase
   end

   always_comb begin
      state_next = link_st;
      unique case (state.mode)
         MODE_IDLE: begin
            state_next.max_entry_time = max_time_adv;
            state_next.min_entry_time = min_time_adv;
            if (phase_adv == PH_UNLOCK) begin
               state_next.mode  = MODE_NORMAL;
               state_next.phase = PH_FREE;
            end else begin
               state_next.phase = phase_adv;
            end
         end
         MODE_NORMAL: begin
            if (link_st.pending_toggle) begin
               state_next.mode           = MODE_HOLD;
               state_next.pending_toggle = 1'b0;
               state_next.height         = item.distance_mm;
            end
            if (!link_st.link) begin
               state_next.mode = MODE_FAIL;
            end
         end
         MODE_HOLD: begin
            if (link_st.pending_toggle) begin
               state_next.mode           = MODE_NORMAL;
               state_next.pending_toggle = 1'b0;
            end
            if (!link_st.link) begin
               state_next.mode = MODE_FAIL;
            end
         end
         default: begin
            if (item.motors_stopped) begin
               state_next.mode = MODE_IDLE;
            end
         end
      endcase
   end

endmodule

// File: hdl/flight_mode_arming_controller.sv
// ----------------------------------------------------------------------------
// Flight mode arming controller
// Link supervision, stick arming sequence and flight mode state machine.
// ----------------------------------------------------------------------------
// One control period item is accepted every clock cycle unless the result stalls.
// The item is captured in an input register, the link, arming and mode update is
// evaluated in a single pass against the held state, and the result is offered from
// an output register. A stalled result holds the output register while the input
// register keeps one more item, so throughput stays at one item per cycle whenever
// the result side takes a transfer every cycle.
module flight_mode_arming_controller (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [fmac_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fmac_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   fmac_req_if.sink                              req,
   fmac_rsp_if.source                            rsp
);
   import fmac_pkg::*;

   `include "flight_mode_arming_controller_macros.svh"

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   item_type  item_ff;
   item_type  item_in;
   logic      item_valid_ff;
   logic      item_valid_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic [1:0]  mode_out_ff;
   logic [1:0]  mode_out_in;
   logic [2:0]  phase_out_ff;
   logic [2:0]  phase_out_in;
   logic        link_out_ff;
   logic        link_out_in;
   logic [15:0] height_out_ff;
   logic [15:0] height_out_in;
   state_type state_next;
   logic      advance;
   logic      req_transfer;

   fmac_step u_step (
      .cfg        (cfg_ff),
      .item       (item_ff),
      .state      (state_ff),
      .state_next (state_next)
   );

   assign advance      = item_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready    = !item_valid_ff || advance;
   assign req_transfer = req.valid && req.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MISS_LIMIT:     cfg_in.miss_limit     = csr_wdata[7:0];
            REG_HIGH_THRESHOLD: cfg_in.high_threshold = csr_wdata[9:0];
            REG_LOW_THRESHOLD:  cfg_in.low_threshold  = csr_wdata[9:0];
            REG_HOLD_MS:        cfg_in.hold_ms        = csr_wdata[15:0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !advance;
      if (req_transfer) begin
         item_valid_in        = 1'b1;
         item_in.rx_ok          = req.rx_ok;
         item_in.throttle       = req.throttle;
         item_in.height_toggle  = req.height_toggle;
         item_in.now_ms         = req.now_ms;
         item_in.distance_mm    = req.distance_mm;
         item_in.motors_stopped = req.motors_stopped;
      end
   end

   always_comb begin
      state_in      = advance ? state_next : state_ff;
      out_valid_in  = advance || (out_valid_ff && !rsp.ready);
      mode_out_in   = advance ? state_next.mode   : mode_out_ff;
      phase_out_in  = advance ? state_next.phase  : phase_out_ff;
      link_out_in   = advance ? state_next.link   : link_out_ff;
      height_out_in = advance ? state_next.height : height_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '{miss_limit: MISS_LIMIT_RESET,
                            high_threshold: HIGH_THRESHOLD_RESET,
                            low_threshold: LOW_THRESHOLD_RESET,
                            hold_ms: HOLD_MS_RESET};
         state_ff      <= STATE_RESET;
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      mode_out_ff   <= mode_out_in;
      phase_out_ff  <= phase_out_in;
      link_out_ff   <= link_out_in;
      height_out_ff <= height_out_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.flight_mode = mode_out_ff;
   assign rsp.arm_phase   = phase_out_ff;
   assign rsp.link_up     = link_out_ff;
   assign rsp.held_height = height_out_ff;

   `FMAC_ASSERT_ALWAYS(a_reset_empties, reset |=> !item_valid_ff && !out_valid_ff, "not empty")
   `FMAC_ASSERT(a_no_stored_unlock, state_ff.phase != PH_UNLOCK, "unlock phase held in state")
   `FMAC_ASSERT(a_phase_free_armed, state_ff.mode != MODE_IDLE |-> state_ff.phase == PH_FREE, "phase")
   `FMAC_ASSERT(a_ready_when_drained, !out_valid_ff |-> req.ready, "input stalled with empty output")

endmodule
